// ===== rtl/segment_intersection_test_macros.svh =====
// ----------------------------------------------------------------------------
// Segment intersection test assertion macros
// Shared concurrent assertion forms used by the intersection test RTL.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_TEST_MACROS_SVH
`define SEGMENT_INTERSECTION_TEST_MACROS_SVH

`ifndef SYNTHESIS

// Plain property, sampled on the rising clock edge, off during reset.
`define SIT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Overlapping implication, sampled on the rising clock edge, off during reset.
`define SIT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define SIT_ASSERT(lbl, clk, rst_n, prop)
`define SIT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/sit_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment intersection test package
// Fixed constants and types of the intersection test block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sit_pkg;

    // Width of the tolerance register.
    localparam int TOL_BITS = 16;

    // The slack is tolerance * root / 2^TOL_SHIFT.
    localparam int TOL_SHIFT = 16;

    // Near parallel when |d| * 2^PAR_SHIFT is below the shorter squared length.
    localparam int PAR_SHIFT = 27;

    typedef logic [TOL_BITS-1:0] tol_t;

endpackage

// ===== rtl/segment_intersection_test.sv =====
// ----------------------------------------------------------------------------
// Segment intersection test
// Decides whether two 2D fixed-point segments cross and reports the point.
// ----------------------------------------------------------------------------
// A request is taken on every cycle in which start is high; busy is always low,
// so one pair of segments can follow another on every clock. The result shows
// up on done, hit, point_valid, cross_x and cross_y for exactly one cycle, and
// the receiver cannot stall it. The crossing point is formed by a row of divider
// cells, one quotient bit per cell; the square root for the slack runs in a
// shorter row alongside it. The tolerance register may be written only while
// no request is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "segment_intersection_test_macros.svh"

module segment_intersection_test #(
    parameter int COORD_BITS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] a_start_x,
    input  logic signed [COORD_BITS-1:0] a_start_y,
    input  logic signed [COORD_BITS-1:0] a_end_x,
    input  logic signed [COORD_BITS-1:0] a_end_y,
    input  logic signed [COORD_BITS-1:0] b_start_x,
    input  logic signed [COORD_BITS-1:0] b_start_y,
    input  logic signed [COORD_BITS-1:0] b_end_x,
    input  logic signed [COORD_BITS-1:0] b_end_y,
    input  logic                         tolerance_we,
    input  sit_pkg::tol_t                tolerance,
    output logic                         done,
    output logic                         hit,
    output logic                         point_valid,
    output logic signed [COORD_BITS-1:0] cross_x,
    output logic signed [COORD_BITS-1:0] cross_y
);

    localparam int CB      = COORD_BITS;
    localparam int QB      = CB + 4;       // quotient bits
    localparam int RB      = CB + 1;       // root bits
    localparam int NW      = 3 * CB + 3;   // numerator width
    localparam int DW      = 2 * CB + 3;   // determinant and divisor width
    localparam int RW      = DW + 1;       // remainder width
    localparam int LW      = 2 * CB + 2;   // squared length width
    localparam int PW      = QB + 2;       // point width for the bounds test
    localparam int EW      = RB;           // slack width
    localparam int MMW     = 8 * CB;
    localparam int SW      = MMW + 6;
    localparam int LATENCY = QB + 9;

    localparam int B_OVFY  = MMW;
    localparam int B_OVFX  = MMW + 1;
    localparam int B_NEGY  = MMW + 2;
    localparam int B_NEGX  = MMW + 3;
    localparam int B_PAR   = MMW + 4;
    localparam int B_BOXES = MMW + 5;

    // Order of the box limits inside the packed limit vector.
    localparam int MM_MINXA = 0;
    localparam int MM_MAXXA = 1;
    localparam int MM_MINYA = 2;
    localparam int MM_MAXYA = 3;
    localparam int MM_MINXB = 4;
    localparam int MM_MAXXB = 5;
    localparam int MM_MINYB = 6;
    localparam int MM_MAXYB = 7;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    sit_pkg::tol_t tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= '0;
        end
        else if (tolerance_we)
        begin
            tol_reg <= tolerance;
        end
    end

    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Valid pipeline through the front stages
    // ------------------------------------------------------------------
    logic [6:0] vf_reg;
    logic [6:0] vf_next;

    assign vf_next = {vf_reg[5:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf_reg <= '0;
        end
        else
        begin
            vf_reg <= vf_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: differences, cross products of endpoints, box limits
    // ------------------------------------------------------------------
    logic signed [CB:0]     dxa_s1_reg, dya_s1_reg, dxb_s1_reg, dyb_s1_reg;
    logic signed [CB:0]     dxa_s1_next, dya_s1_next, dxb_s1_next, dyb_s1_next;
    logic signed [2*CB-1:0] p1_s1_reg, p2_s1_reg, p3_s1_reg, p4_s1_reg;
    logic signed [2*CB-1:0] p1_s1_next, p2_s1_next, p3_s1_next, p4_s1_next;
    logic [MMW-1:0]         mm_s1_reg;
    logic [MMW-1:0]         mm_s1_next;

    always_comb
    begin
        dxa_s1_next = {a_start_x[CB-1], a_start_x} - {a_end_x[CB-1], a_end_x};
        dya_s1_next = {a_start_y[CB-1], a_start_y} - {a_end_y[CB-1], a_end_y};
        dxb_s1_next = {b_start_x[CB-1], b_start_x} - {b_end_x[CB-1], b_end_x};
        dyb_s1_next = {b_start_y[CB-1], b_start_y} - {b_end_y[CB-1], b_end_y};
        p1_s1_next  = a_start_x * a_end_y;
        p2_s1_next  = a_end_x * a_start_y;
        p3_s1_next  = b_start_x * b_end_y;
        p4_s1_next  = b_end_x * b_start_y;
        mm_s1_next[MM_MINXA*CB +: CB] = (a_start_x < a_end_x) ? a_start_x : a_end_x;
        mm_s1_next[MM_MAXXA*CB +: CB] = (a_start_x > a_end_x) ? a_start_x : a_end_x;
        mm_s1_next[MM_MINYA*CB +: CB] = (a_start_y < a_end_y) ? a_start_y : a_end_y;
        mm_s1_next[MM_MAXYA*CB +: CB] = (a_start_y > a_end_y) ? a_start_y : a_end_y;
        mm_s1_next[MM_MINXB*CB +: CB] = (b_start_x < b_end_x) ? b_start_x : b_end_x;
        mm_s1_next[MM_MAXXB*CB +: CB] = (b_start_x > b_end_x) ? b_start_x : b_end_x;
        mm_s1_next[MM_MINYB*CB +: CB] = (b_start_y < b_end_y) ? b_start_y : b_end_y;
        mm_s1_next[MM_MAXYB*CB +: CB] = (b_start_y > b_end_y) ? b_start_y : b_end_y;
    end

    always_ff @(posedge clk)
    begin
        dxa_s1_reg <= dxa_s1_next;
        dya_s1_reg <= dya_s1_next;
        dxb_s1_reg <= dxb_s1_next;
        dyb_s1_reg <= dyb_s1_next;
        p1_s1_reg  <= p1_s1_next;
        p2_s1_reg  <= p2_s1_next;
        p3_s1_reg  <= p3_s1_next;
        p4_s1_reg  <= p4_s1_next;
        mm_s1_reg  <= mm_s1_next;
    end

    // ------------------------------------------------------------------
    // Stage 2: line constants, squares, determinant products, box overlap
    // ------------------------------------------------------------------
    logic signed [CB:0]     dxa_s2_reg, dya_s2_reg, dxb_s2_reg, dyb_s2_reg;
    logic signed [2*CB:0]   ca_s2_reg, cb_s2_reg;
    logic signed [2*CB:0]   ca_s2_next, cb_s2_next;
    logic signed [2*CB+1:0] sxa_s2_reg, sya_s2_reg, sxb_s2_reg, syb_s2_reg;
    logic signed [2*CB+1:0] sxa_s2_next, sya_s2_next, sxb_s2_next, syb_s2_next;
    logic signed [2*CB+1:0] m1_s2_reg, m2_s2_reg;
    logic signed [2*CB+1:0] m1_s2_next, m2_s2_next;
    logic                   boxes_s2_reg;
    logic                   boxes_s2_next;
    logic [MMW-1:0]         mm_s2_reg;

    always_comb
    begin
        ca_s2_next  = {p1_s1_reg[2*CB-1], p1_s1_reg} - {p2_s1_reg[2*CB-1], p2_s1_reg};
        cb_s2_next  = {p3_s1_reg[2*CB-1], p3_s1_reg} - {p4_s1_reg[2*CB-1], p4_s1_reg};
        sxa_s2_next = dxa_s1_reg * dxa_s1_reg;
        sya_s2_next = dya_s1_reg * dya_s1_reg;
        sxb_s2_next = dxb_s1_reg * dxb_s1_reg;
        syb_s2_next = dyb_s1_reg * dyb_s1_reg;
        m1_s2_next  = dxa_s1_reg * dyb_s1_reg;
        m2_s2_next  = dxb_s1_reg * dya_s1_reg;
        boxes_s2_next = !(
            ($signed(mm_s1_reg[MM_MINXA*CB +: CB]) > $signed(mm_s1_reg[MM_MAXXB*CB +: CB])) ||
            ($signed(mm_s1_reg[MM_MINXB*CB +: CB]) > $signed(mm_s1_reg[MM_MAXXA*CB +: CB])) ||
            ($signed(mm_s1_reg[MM_MINYA*CB +: CB]) > $signed(mm_s1_reg[MM_MAXYB*CB +: CB])) ||
            ($signed(mm_s1_reg[MM_MINYB*CB +: CB]) > $signed(mm_s1_reg[MM_MAXYA*CB +: CB])));
    end

    always_ff @(posedge clk)
    begin
        dxa_s2_reg   <= dxa_s1_reg;
        dya_s2_reg   <= dya_s1_reg;
        dxb_s2_reg   <= dxb_s1_reg;
        dyb_s2_reg   <= dyb_s1_reg;
        ca_s2_reg    <= ca_s2_next;
        cb_s2_reg    <= cb_s2_next;
        sxa_s2_reg   <= sxa_s2_next;
        sya_s2_reg   <= sya_s2_next;
        sxb_s2_reg   <= sxb_s2_next;
        syb_s2_reg   <= syb_s2_next;
        m1_s2_reg    <= m1_s2_next;
        m2_s2_reg    <= m2_s2_next;
        boxes_s2_reg <= boxes_s2_next;
        mm_s2_reg    <= mm_s1_reg;
    end

    // ------------------------------------------------------------------
    // Stage 3: squared lengths, determinant, numerator partial products
    // ------------------------------------------------------------------
    // The line constants are split into a signed high half and an unsigned
    // low half so that every multiplier stays near the coordinate width.
    logic [LW-1:0]          la_s3_reg, lb_s3_reg;
    logic [LW-1:0]          la_s3_next, lb_s3_next;
    logic signed [DW-1:0]   d_s3_reg;
    logic signed [DW-1:0]   d_s3_next;
    logic signed [2*CB+1:0] xah_s3_reg, xal_s3_reg, xbh_s3_reg, xbl_s3_reg;
    logic signed [2*CB+1:0] yah_s3_reg, yal_s3_reg, ybh_s3_reg, ybl_s3_reg;
    logic signed [2*CB+1:0] xah_s3_next, xal_s3_next, xbh_s3_next, xbl_s3_next;
    logic signed [2*CB+1:0] yah_s3_next, yal_s3_next, ybh_s3_next, ybl_s3_next;
    logic signed [CB:0]     cah_w, cbh_w, cal_w, cbl_w;
    logic                   boxes_s3_reg;
    logic [MMW-1:0]         mm_s3_reg;

    always_comb
    begin
        cah_w       = ca_s2_reg[2*CB:CB];
        cbh_w       = cb_s2_reg[2*CB:CB];
        cal_w       = {1'b0, ca_s2_reg[CB-1:0]};
        cbl_w       = {1'b0, cb_s2_reg[CB-1:0]};
        la_s3_next  = sxa_s2_reg + sya_s2_reg;
        lb_s3_next  = sxb_s2_reg + syb_s2_reg;
        d_s3_next   = {m1_s2_reg[2*CB+1], m1_s2_reg} - {m2_s2_reg[2*CB+1], m2_s2_reg};
        xah_s3_next = dxb_s2_reg * cah_w;
        xal_s3_next = dxb_s2_reg * cal_w;
        xbh_s3_next = dxa_s2_reg * cbh_w;
        xbl_s3_next = dxa_s2_reg * cbl_w;
        yah_s3_next = dyb_s2_reg * cah_w;
        yal_s3_next = dyb_s2_reg * cal_w;
        ybh_s3_next = dya_s2_reg * cbh_w;
        ybl_s3_next = dya_s2_reg * cbl_w;
    end

    always_ff @(posedge clk)
    begin
        la_s3_reg    <= la_s3_next;
        lb_s3_reg    <= lb_s3_next;
        d_s3_reg     <= d_s3_next;
        xah_s3_reg   <= xah_s3_next;
        xal_s3_reg   <= xal_s3_next;
        xbh_s3_reg   <= xbh_s3_next;
        xbl_s3_reg   <= xbl_s3_next;
        yah_s3_reg   <= yah_s3_next;
        yal_s3_reg   <= yal_s3_next;
        ybh_s3_reg   <= ybh_s3_next;
        ybl_s3_reg   <= ybl_s3_next;
        boxes_s3_reg <= boxes_s2_reg;
        mm_s3_reg    <= mm_s2_reg;
    end

    // ------------------------------------------------------------------
    // Stage 4: shorter length, determinant magnitude, partial sums
    // ------------------------------------------------------------------
    logic [LW-1:0]        l_s4_reg;
    logic [LW-1:0]        l_s4_next;
    logic [DW-1:0]        ad_s4_reg;
    logic [DW-1:0]        ad_s4_next;
    logic                 dneg_s4_reg, dzero_s4_reg;
    logic                 dneg_s4_next, dzero_s4_next;
    logic signed [NW-1:0] pax_s4_reg, pbx_s4_reg, pay_s4_reg, pby_s4_reg;
    logic signed [NW-1:0] pax_s4_next, pbx_s4_next, pay_s4_next, pby_s4_next;
    logic                 boxes_s4_reg;
    logic [MMW-1:0]       mm_s4_reg;

    always_comb
    begin
        l_s4_next     = (la_s3_reg < lb_s3_reg) ? la_s3_reg : lb_s3_reg;
        dneg_s4_next  = d_s3_reg[DW-1];
        dzero_s4_next = (d_s3_reg == '0);
        ad_s4_next    = d_s3_reg[DW-1] ? (-d_s3_reg) : d_s3_reg;
        pax_s4_next   = ({{(NW-2*CB-2){xah_s3_reg[2*CB+1]}}, xah_s3_reg} <<< CB) +
                        {{(NW-2*CB-2){xal_s3_reg[2*CB+1]}}, xal_s3_reg};
        pbx_s4_next   = ({{(NW-2*CB-2){xbh_s3_reg[2*CB+1]}}, xbh_s3_reg} <<< CB) +
                        {{(NW-2*CB-2){xbl_s3_reg[2*CB+1]}}, xbl_s3_reg};
        pay_s4_next   = ({{(NW-2*CB-2){yah_s3_reg[2*CB+1]}}, yah_s3_reg} <<< CB) +
                        {{(NW-2*CB-2){yal_s3_reg[2*CB+1]}}, yal_s3_reg};
        pby_s4_next   = ({{(NW-2*CB-2){ybh_s3_reg[2*CB+1]}}, ybh_s3_reg} <<< CB) +
                        {{(NW-2*CB-2){ybl_s3_reg[2*CB+1]}}, ybl_s3_reg};
    end

    always_ff @(posedge clk)
    begin
        l_s4_reg     <= l_s4_next;
        ad_s4_reg    <= ad_s4_next;
        dneg_s4_reg  <= dneg_s4_next;
        dzero_s4_reg <= dzero_s4_next;
        pax_s4_reg   <= pax_s4_next;
        pbx_s4_reg   <= pbx_s4_next;
        pay_s4_reg   <= pay_s4_next;
        pby_s4_reg   <= pby_s4_next;
        boxes_s4_reg <= boxes_s3_reg;
        mm_s4_reg    <= mm_s3_reg;
    end

    // ------------------------------------------------------------------
    // Stage 5: near-parallel decision, numerators, divisor
    // ------------------------------------------------------------------
    logic [LW-1:0]        l_s5_reg;
    logic [DW-1:0]        ad_s5_reg;
    logic [DW-1:0]        dv_s5_reg;
    logic [DW-1:0]        dv_s5_next;
    logic                 dneg_s5_reg;
    logic                 par_s5_reg;
    logic                 par_s5_next;
    logic signed [NW-1:0] nx_s5_reg, ny_s5_reg;
    logic signed [NW-1:0] nx_s5_next, ny_s5_next;
    logic                 boxes_s5_reg;
    logic [MMW-1:0]       mm_s5_reg;

    always_comb
    begin
        par_s5_next = dzero_s4_reg ||
                      ({ad_s4_reg, {sit_pkg::PAR_SHIFT{1'b0}}} <
                       {{(DW+sit_pkg::PAR_SHIFT-LW){1'b0}}, l_s4_reg});
        nx_s5_next  = pax_s4_reg - pbx_s4_reg;
        ny_s5_next  = pay_s4_reg - pby_s4_reg;
        dv_s5_next  = {ad_s4_reg[DW-2:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        l_s5_reg     <= l_s4_reg;
        ad_s5_reg    <= ad_s4_reg;
        dv_s5_reg    <= dv_s5_next;
        dneg_s5_reg  <= dneg_s4_reg;
        par_s5_reg   <= par_s5_next;
        nx_s5_reg    <= nx_s5_next;
        ny_s5_reg    <= ny_s5_next;
        boxes_s5_reg <= boxes_s4_reg;
        mm_s5_reg    <= mm_s4_reg;
    end

    // ------------------------------------------------------------------
    // Stage 6: rounded dividends 2|n| + |d| and quotient signs
    // ------------------------------------------------------------------
    logic [LW-1:0]  l_s6_reg;
    logic [DW-1:0]  dv_s6_reg;
    logic [NW-1:0]  nux_s6_reg, nuy_s6_reg;
    logic [NW-1:0]  nux_s6_next, nuy_s6_next;
    logic [NW-1:0]  ad_ext_w, nx2_w, ny2_w;
    logic           negx_s6_reg, negy_s6_reg;
    logic           negx_s6_next, negy_s6_next;
    logic           par_s6_reg;
    logic           boxes_s6_reg;
    logic [MMW-1:0] mm_s6_reg;

    always_comb
    begin
        ad_ext_w     = {{(NW-DW){1'b0}}, ad_s5_reg};
        nx2_w        = {nx_s5_reg[NW-2:0], 1'b0};
        ny2_w        = {ny_s5_reg[NW-2:0], 1'b0};
        nux_s6_next  = nx_s5_reg[NW-1] ? (ad_ext_w - nx2_w) : (ad_ext_w + nx2_w);
        nuy_s6_next  = ny_s5_reg[NW-1] ? (ad_ext_w - ny2_w) : (ad_ext_w + ny2_w);
        negx_s6_next = nx_s5_reg[NW-1] ^ dneg_s5_reg;
        negy_s6_next = ny_s5_reg[NW-1] ^ dneg_s5_reg;
    end

    always_ff @(posedge clk)
    begin
        l_s6_reg     <= l_s5_reg;
        dv_s6_reg    <= dv_s5_reg;
        nux_s6_reg   <= nux_s6_next;
        nuy_s6_reg   <= nuy_s6_next;
        negx_s6_reg  <= negx_s6_next;
        negy_s6_reg  <= negy_s6_next;
        par_s6_reg   <= par_s5_reg;
        boxes_s6_reg <= boxes_s5_reg;
        mm_s6_reg    <= mm_s5_reg;
    end

    // ------------------------------------------------------------------
    // Stage 7: quotient overflow and initial remainders
    // ------------------------------------------------------------------
    // A quotient that does not fit in QB bits lies far outside every box and
    // every output limit, so it is clamped instead of divided out in full.
    logic [LW-1:0] l_s7_reg;
    logic [DW-1:0] dv_s7_reg;
    logic [RW-1:0] rx_s7_reg, ry_s7_reg;
    logic [RW-1:0] rx_s7_next, ry_s7_next;
    logic [QB-1:0] nbx_s7_reg, nby_s7_reg;
    logic [RW-1:0] dv_ext_w;
    logic [SW-1:0] side_s7_reg;
    logic [SW-1:0] side_s7_next;

    always_comb
    begin
        dv_ext_w   = {1'b0, dv_s6_reg};
        rx_s7_next = {{(RW-NW+QB){1'b0}}, nux_s6_reg[NW-1:QB]};
        ry_s7_next = {{(RW-NW+QB){1'b0}}, nuy_s6_reg[NW-1:QB]};
        side_s7_next = {boxes_s6_reg, par_s6_reg, negx_s6_reg, negy_s6_reg,
                        (rx_s7_next >= dv_ext_w), (ry_s7_next >= dv_ext_w), mm_s6_reg};
    end

    always_ff @(posedge clk)
    begin
        l_s7_reg    <= l_s6_reg;
        dv_s7_reg   <= dv_s6_reg;
        rx_s7_reg   <= rx_s7_next;
        ry_s7_reg   <= ry_s7_next;
        nbx_s7_reg  <= nux_s6_reg[QB-1:0];
        nby_s7_reg  <= nuy_s6_reg[QB-1:0];
        side_s7_reg <= side_s7_next;
    end

    // ------------------------------------------------------------------
    // Divider and square root rows
    // ------------------------------------------------------------------
    logic [DW-1:0]   dv_w  [0:QB];
    logic [RW-1:0]   rx_w  [0:QB];
    logic [RW-1:0]   ry_w  [0:QB];
    logic [QB-1:0]   nbx_w [0:QB];
    logic [QB-1:0]   nby_w [0:QB];
    logic [QB-1:0]   qx_w  [0:QB];
    logic [QB-1:0]   qy_w  [0:QB];

    logic [2*RB-1:0] sa_w    [0:RB];
    logic [RB+1:0]   srem_w  [0:RB];
    logic [RB-1:0]   sroot_w [0:RB];

    assign dv_w[0]    = dv_s7_reg;
    assign rx_w[0]    = rx_s7_reg;
    assign ry_w[0]    = ry_s7_reg;
    assign nbx_w[0]   = nbx_s7_reg;
    assign nby_w[0]   = nby_s7_reg;
    assign qx_w[0]    = '0;
    assign qy_w[0]    = '0;

    assign sa_w[0]    = l_s7_reg;
    assign srem_w[0]  = '0;
    assign sroot_w[0] = '0;

    for (genvar gi = 0; gi < QB; gi++)
    begin : g_div
        sit_div_cell #(
            .DW (DW),
            .NB (QB)
        ) u_cell (
            .clk     (clk),
            .d_in    (dv_w[gi]),
            .rx_in   (rx_w[gi]),
            .ry_in   (ry_w[gi]),
            .nbx_in  (nbx_w[gi]),
            .nby_in  (nby_w[gi]),
            .qx_in   (qx_w[gi]),
            .qy_in   (qy_w[gi]),
            .d_out   (dv_w[gi+1]),
            .rx_out  (rx_w[gi+1]),
            .ry_out  (ry_w[gi+1]),
            .nbx_out (nbx_w[gi+1]),
            .nby_out (nby_w[gi+1]),
            .qx_out  (qx_w[gi+1]),
            .qy_out  (qy_w[gi+1])
        );
    end

    for (genvar gj = 0; gj < RB; gj++)
    begin : g_sqrt
        sit_sqrt_cell #(
            .RB (RB)
        ) u_cell (
            .clk      (clk),
            .a_in     (sa_w[gj]),
            .rem_in   (srem_w[gj]),
            .root_in  (sroot_w[gj]),
            .a_out    (sa_w[gj+1]),
            .rem_out  (srem_w[gj+1]),
            .root_out (sroot_w[gj+1])
        );
    end

    // Side data and valid bits that travel with the divider row.
    logic [SW-1:0] side_dly_reg [0:QB-1];
    logic [QB-1:0] vd_reg;
    logic [QB-1:0] vd_next;

    assign vd_next = {vd_reg[QB-2:0], vf_reg[6]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vd_reg <= '0;
        end
        else
        begin
            vd_reg <= vd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        side_dly_reg[0] <= side_s7_reg;
        for (int i = 1; i < QB; i++)
        begin
            side_dly_reg[i] <= side_dly_reg[i-1];
        end
    end

    // Slack from the root, then two stages so it lines up with the quotients.
    logic [sit_pkg::TOL_BITS+RB-1:0] eps_prod_w;
    logic [EW-1:0]                   eps_reg;
    logic [EW-1:0]                   eps_next;
    logic [EW-1:0]                   eps_d1_reg;
    logic [EW-1:0]                   eps_d2_reg;

    assign eps_prod_w = tol_reg * sroot_w[RB];
    assign eps_next   = eps_prod_w[sit_pkg::TOL_SHIFT +: EW];

    always_ff @(posedge clk)
    begin
        eps_reg    <= eps_next;
        eps_d1_reg <= eps_reg;
        eps_d2_reg <= eps_d1_reg;
    end

    // ------------------------------------------------------------------
    // Stage B: signed, clamped crossing point
    // ------------------------------------------------------------------
    logic [SW-1:0]        side_b;
    logic [QB-1:0]        magx_w, magy_w;
    logic signed [PW-1:0] px_b_reg, py_b_reg;
    logic signed [PW-1:0] px_b_next, py_b_next;
    logic [EW-1:0]        eps_b_reg;
    logic [SW-1:0]        side_b_reg;
    logic                 vb_reg;

    always_comb
    begin
        side_b    = side_dly_reg[QB-1];
        magx_w    = side_b[B_OVFX] ? {QB{1'b1}} : qx_w[QB];
        magy_w    = side_b[B_OVFY] ? {QB{1'b1}} : qy_w[QB];
        px_b_next = side_b[B_NEGX] ? -$signed({2'b00, magx_w}) : $signed({2'b00, magx_w});
        py_b_next = side_b[B_NEGY] ? -$signed({2'b00, magy_w}) : $signed({2'b00, magy_w});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
        end
        else
        begin
            vb_reg <= vd_reg[QB-1];
        end
    end

    always_ff @(posedge clk)
    begin
        px_b_reg   <= px_b_next;
        py_b_reg   <= py_b_next;
        eps_b_reg  <= eps_d2_reg;
        side_b_reg <= side_b;
    end

    // ------------------------------------------------------------------
    // Stage C: bounds test, saturation, result registers
    // ------------------------------------------------------------------
    logic signed [PW-1:0] eps_e;
    logic signed [PW-1:0] lim_e [0:7];
    logic signed [PW-1:0] pxp_w, pxm_w, pyp_w, pym_w;
    logic signed [PW-1:0] max_c, min_c;
    logic                 out_any;
    logic                 par_c;

    logic                 done_reg, hit_reg, point_valid_reg;
    logic                 hit_next, point_valid_next;
    logic [CB-1:0]        cross_x_reg, cross_y_reg;
    logic [CB-1:0]        cross_x_next, cross_y_next;

    always_comb
    begin
        eps_e = $signed({{(PW-EW){1'b0}}, eps_b_reg});
        for (int k = 0; k < 8; k++)
        begin
            lim_e[k] = $signed({{(PW-CB){side_b_reg[k*CB+CB-1]}}, side_b_reg[k*CB +: CB]});
        end
        max_c = $signed({{(PW-CB+1){1'b0}}, {(CB-1){1'b1}}});
        min_c = $signed({{(PW-CB+1){1'b1}}, {(CB-1){1'b0}}});
        pxp_w = px_b_reg + eps_e;
        pxm_w = px_b_reg - eps_e;
        pyp_w = py_b_reg + eps_e;
        pym_w = py_b_reg - eps_e;
        out_any = (pxp_w < lim_e[MM_MINXA]) || (pxm_w > lim_e[MM_MAXXA]) ||
                  (pxp_w < lim_e[MM_MINXB]) || (pxm_w > lim_e[MM_MAXXB]) ||
                  (pyp_w < lim_e[MM_MINYA]) || (pym_w > lim_e[MM_MAXYA]) ||
                  (pyp_w < lim_e[MM_MINYB]) || (pym_w > lim_e[MM_MAXYB]);
        par_c            = side_b_reg[B_PAR];
        point_valid_next = !par_c;
        hit_next         = !par_c && side_b_reg[B_BOXES] && !out_any;

        priority if (par_c)
        begin
            cross_x_next = '0;
        end
        else if (px_b_reg > max_c)
        begin
            cross_x_next = max_c[CB-1:0];
        end
        else if (px_b_reg < min_c)
        begin
            cross_x_next = min_c[CB-1:0];
        end
        else
        begin
            cross_x_next = px_b_reg[CB-1:0];
        end

        priority if (par_c)
        begin
            cross_y_next = '0;
        end
        else if (py_b_reg > max_c)
        begin
            cross_y_next = max_c[CB-1:0];
        end
        else if (py_b_reg < min_c)
        begin
            cross_y_next = min_c[CB-1:0];
        end
        else
        begin
            cross_y_next = py_b_reg[CB-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg         <= hit_next;
        point_valid_reg <= point_valid_next;
        cross_x_reg     <= cross_x_next;
        cross_y_reg     <= cross_y_next;
    end

    assign done        = done_reg;
    assign hit         = hit_reg;
    assign point_valid = point_valid_reg;
    assign cross_x     = cross_x_reg;
    assign cross_y     = cross_y_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SIT_ASSERT_IMPL(a_latency, clk, rst_n, start, ##LATENCY done)
    `SIT_ASSERT_IMPL(a_hit_needs_point, clk, rst_n, done && hit, point_valid)
    `SIT_ASSERT_IMPL(a_no_point_is_zero, clk, rst_n, done && !point_valid, (cross_x == '0) && (cross_y == '0))
    `SIT_ASSERT_IMPL(a_div_remainder, clk, rst_n, vd_reg[QB-1], (side_b[B_OVFX] || (rx_w[QB] < {1'b0, dv_w[QB]})) && (side_b[B_OVFY] || (ry_w[QB] < {1'b0, dv_w[QB]})) && (nbx_w[QB] == '0) && (nby_w[QB] == '0))
    `SIT_ASSERT_IMPL(a_sqrt_remainder, clk, rst_n, vd_reg[RB-1], (srem_w[RB] <= {1'b0, sroot_w[RB], 1'b0}) && (sa_w[RB] == '0))

endmodule

// ===== rtl/sit_div_cell.sv =====
// ----------------------------------------------------------------------------
// Segment intersection test divider cell
// One restoring division step for the x and y quotients, which share a divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sit_div_cell #(
    parameter int DW = 51,
    parameter int NB = 28
) (
    input  logic          clk,
    input  logic [DW-1:0] d_in,
    input  logic [DW:0]   rx_in,
    input  logic [DW:0]   ry_in,
    input  logic [NB-1:0] nbx_in,
    input  logic [NB-1:0] nby_in,
    input  logic [NB-1:0] qx_in,
    input  logic [NB-1:0] qy_in,
    output logic [DW-1:0] d_out,
    output logic [DW:0]   rx_out,
    output logic [DW:0]   ry_out,
    output logic [NB-1:0] nbx_out,
    output logic [NB-1:0] nby_out,
    output logic [NB-1:0] qx_out,
    output logic [NB-1:0] qy_out
);

    logic [DW:0]   rx_shift;
    logic [DW:0]   ry_shift;
    logic [DW:0]   d_ext;
    logic          gex;
    logic          gey;

    logic [DW-1:0] d_reg;
    logic [DW:0]   rx_reg;
    logic [DW:0]   ry_reg;
    logic [NB-1:0] nbx_reg;
    logic [NB-1:0] nby_reg;
    logic [NB-1:0] qx_reg;
    logic [NB-1:0] qy_reg;

    logic [DW:0]   rx_next;
    logic [DW:0]   ry_next;
    logic [NB-1:0] nbx_next;
    logic [NB-1:0] nby_next;
    logic [NB-1:0] qx_next;
    logic [NB-1:0] qy_next;

    // The incoming remainder is below the divisor, so its top bit is zero.
    always_comb
    begin
        d_ext    = {1'b0, d_in};
        rx_shift = {rx_in[DW-1:0], nbx_in[NB-1]};
        ry_shift = {ry_in[DW-1:0], nby_in[NB-1]};
        gex      = (rx_shift >= d_ext);
        gey      = (ry_shift >= d_ext);
        rx_next  = gex ? (rx_shift - d_ext) : rx_shift;
        ry_next  = gey ? (ry_shift - d_ext) : ry_shift;
        nbx_next = {nbx_in[NB-2:0], 1'b0};
        nby_next = {nby_in[NB-2:0], 1'b0};
        qx_next  = {qx_in[NB-2:0], gex};
        qy_next  = {qy_in[NB-2:0], gey};
    end

    always_ff @(posedge clk)
    begin
        d_reg   <= d_in;
        rx_reg  <= rx_next;
        ry_reg  <= ry_next;
        nbx_reg <= nbx_next;
        nby_reg <= nby_next;
        qx_reg  <= qx_next;
        qy_reg  <= qy_next;
    end

    assign d_out   = d_reg;
    assign rx_out  = rx_reg;
    assign ry_out  = ry_reg;
    assign nbx_out = nbx_reg;
    assign nby_out = nby_reg;
    assign qx_out  = qx_reg;
    assign qy_out  = qy_reg;

endmodule

// ===== rtl/sit_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// Segment intersection test square root cell
// One digit-by-digit step of the integer square root, one root bit per cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sit_sqrt_cell #(
    parameter int RB = 25
) (
    input  logic            clk,
    input  logic [2*RB-1:0] a_in,
    input  logic [RB+1:0]   rem_in,
    input  logic [RB-1:0]   root_in,
    output logic [2*RB-1:0] a_out,
    output logic [RB+1:0]   rem_out,
    output logic [RB-1:0]   root_out
);

    logic [RB+1:0]   rem_shift;
    logic [RB+1:0]   trial;
    logic            ge;

    logic [2*RB-1:0] a_reg;
    logic [RB+1:0]   rem_reg;
    logic [RB-1:0]   root_reg;

    logic [2*RB-1:0] a_next;
    logic [RB+1:0]   rem_next;
    logic [RB-1:0]   root_next;

    // Bring down the next two radicand bits and try appending a one to the root.
    always_comb
    begin
        rem_shift = {rem_in[RB-1:0], a_in[2*RB-1:2*RB-2]};
        trial     = {root_in, 2'b01};
        ge        = (rem_shift >= trial);
        rem_next  = ge ? (rem_shift - trial) : rem_shift;
        root_next = {root_in[RB-2:0], ge};
        a_next    = {a_in[2*RB-3:0], 2'b00};
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign a_out    = a_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

// ===== bench/segment_intersection_test_checker.sv =====
// ----------------------------------------------------------------------------
// Segment intersection test checker
// Watches the request and result channels of the intersection block, predicts
// each result from the accepted request and the current tolerance, and compares
// the results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_intersection_test_checker #(
    parameter int COORD_BITS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic signed [COORD_BITS-1:0] a_start_x,
    input  logic signed [COORD_BITS-1:0] a_start_y,
    input  logic signed [COORD_BITS-1:0] a_end_x,
    input  logic signed [COORD_BITS-1:0] a_end_y,
    input  logic signed [COORD_BITS-1:0] b_start_x,
    input  logic signed [COORD_BITS-1:0] b_start_y,
    input  logic signed [COORD_BITS-1:0] b_end_x,
    input  logic signed [COORD_BITS-1:0] b_end_y,
    input  logic                         tolerance_we,
    input  sit_pkg::tol_t                tolerance,
    input  logic                         done,
    input  logic                         hit,
    input  logic                         point_valid,
    input  logic signed [COORD_BITS-1:0] cross_x,
    input  logic signed [COORD_BITS-1:0] cross_y,
    output int                           fail_count,
    output int                           pending
);

    typedef logic signed [127:0] big_t;

    typedef struct packed {
        logic                         hit;
        logic                         point_valid;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } crossing_t;

    crossing_t     crossings_due[$];
    sit_pkg::tol_t tol_reg;

    function automatic big_t round_quotient(big_t num, big_t den);
        logic neg;
        big_t an;
        big_t ad;
        big_t q;
        begin
            neg = (num < 0) != (den < 0);
            an  = (num < 0) ? -num : num;
            ad  = (den < 0) ? -den : den;
            q   = (2 * an + ad) / (2 * ad);
            return neg ? -q : q;
        end
    endfunction

    function automatic big_t root_floor(big_t v);
        big_t s;
        big_t c;
        begin
            s = 0;
            for (int b = 63; b >= 0; b--)
            begin
                c = s | (big_t'(1) << b);
                if (c * c <= v)
                    s = c;
            end
            return s;
        end
    endfunction

    function automatic logic signed [COORD_BITS-1:0] clamp(big_t v);
        big_t mx;
        big_t mn;
        begin
            mx = (big_t'(1) <<< (COORD_BITS - 1)) - 1;
            mn = -mx - 1;
            if (v > mx)
                return mx[COORD_BITS-1:0];
            if (v < mn)
                return mn[COORD_BITS-1:0];
            return v[COORD_BITS-1:0];
        end
    endfunction

    function automatic logic outside(big_t p, big_t eps, big_t u, big_t v);
        big_t lo;
        big_t hi;
        begin
            lo = (u < v) ? u : v;
            hi = (u < v) ? v : u;
            return (p + eps < lo) || (p - eps > hi);
        end
    endfunction

    function automatic crossing_t predict_crossing(big_t x1, big_t y1, big_t x2, big_t y2,
                                                   big_t x3, big_t y3, big_t x4, big_t y4,
                                                   sit_pkg::tol_t tol);
        crossing_t r;
        logic boxes;
        big_t dxa, dya, dxb, dyb, la, lb, len2, det, adet, ca, cb, xi, yi, eps;
        begin
            boxes = !(((x1 < x2) ? x1 : x2) > ((x3 > x4) ? x3 : x4) ||
                      ((x3 < x4) ? x3 : x4) > ((x1 > x2) ? x1 : x2) ||
                      ((y1 < y2) ? y1 : y2) > ((y3 > y4) ? y3 : y4) ||
                      ((y3 < y4) ? y3 : y4) > ((y1 > y2) ? y1 : y2));
            dxa  = x1 - x2;
            dya  = y1 - y2;
            dxb  = x3 - x4;
            dyb  = y3 - y4;
            la   = dxa * dxa + dya * dya;
            lb   = dxb * dxb + dyb * dyb;
            len2 = (la < lb) ? la : lb;
            det  = dxa * dyb - dxb * dya;
            adet = (det < 0) ? -det : det;
            r    = '0;
            if (det == 0 || (adet <<< sit_pkg::PAR_SHIFT) < len2)
                return r;
            ca  = x1 * y2 - x2 * y1;
            cb  = x3 * y4 - x4 * y3;
            xi  = round_quotient(dxb * ca - dxa * cb, det);
            yi  = round_quotient(dyb * ca - dya * cb, det);
            eps = (big_t'(tol) * root_floor(len2)) >>> sit_pkg::TOL_SHIFT;
            r.hit = boxes && !outside(xi, eps, x1, x2) && !outside(xi, eps, x3, x4) &&
                    !outside(yi, eps, y1, y2) && !outside(yi, eps, y3, y4);
            r.point_valid = 1'b1;
            r.x = clamp(xi);
            r.y = clamp(yi);
            return r;
        end
    endfunction

    assign pending = crossings_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        crossing_t want;
        if (!rst_n)
        begin
            tol_reg    <= '0;
            fail_count <= 0;
            crossings_due.delete();
        end
        else
        begin
            if (done)
            begin
                if (crossings_due.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result: hit=%0b valid=%0b x=%0d y=%0d",
                                 hit, point_valid, cross_x, cross_y);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = crossings_due.pop_front();
                    if (want.hit !== hit || want.point_valid !== point_valid ||
                        want.x !== cross_x || want.y !== cross_y)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected hit=%0b valid=%0b x=%0d y=%0d, got hit=%0b valid=%0b x=%0d y=%0d",
                                     want.hit, want.point_valid, want.x, want.y,
                                     hit, point_valid, cross_x, cross_y);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // The request sees the tolerance held before this edge.
            if (start && !busy)
                crossings_due.push_back(predict_crossing(
                    a_start_x, a_start_y, a_end_x, a_end_y,
                    b_start_x, b_start_y, b_end_x, b_end_y, tol_reg));
            if (tolerance_we)
                tol_reg <= tolerance;
        end
    end

endmodule

// ===== bench/segment_intersection_test_tb.sv =====
// ----------------------------------------------------------------------------
// Segment intersection test bench
// Drives directed and random segment pairs at several tolerance settings, with
// random gaps, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_intersection_test_tb;

    localparam int CB        = 24;
    localparam int LATENCY   = CB + 13;
    localparam int MAX_CYCLE = 400000;

    typedef logic signed [CB-1:0] coord_t;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    coord_t        pts [8];
    logic          tolerance_we;
    sit_pkg::tol_t tolerance;
    logic          done;
    logic          hit;
    logic          point_valid;
    coord_t        cross_x;
    coord_t        cross_y;
    int            fail_count;
    int            pending;
    int            cycle_count = 0;

    segment_intersection_test #(.COORD_BITS(CB)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .a_start_x(pts[0]), .a_start_y(pts[1]), .a_end_x(pts[2]), .a_end_y(pts[3]),
        .b_start_x(pts[4]), .b_start_y(pts[5]), .b_end_x(pts[6]), .b_end_y(pts[7]),
        .tolerance_we(tolerance_we), .tolerance(tolerance),
        .done(done), .hit(hit), .point_valid(point_valid),
        .cross_x(cross_x), .cross_y(cross_y)
    );

    segment_intersection_test_checker #(.COORD_BITS(CB)) u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .a_start_x(pts[0]), .a_start_y(pts[1]), .a_end_x(pts[2]), .a_end_y(pts[3]),
        .b_start_x(pts[4]), .b_start_y(pts[5]), .b_end_x(pts[6]), .b_end_y(pts[7]),
        .tolerance_we(tolerance_we), .tolerance(tolerance),
        .done(done), .hit(hit), .point_valid(point_valid),
        .cross_x(cross_x), .cross_y(cross_y),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Sends one request; start stays high when the next request follows at once.
    task automatic send_pair(input coord_t v [8]);
        int gap;
        begin
            gap = ($urandom_range(0, 9) < 6) ? 0 :
                  ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(5, 40);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            start <= 1'b1;
            for (int i = 0; i < 8; i++)
                pts[i] <= v[i];
            @(posedge clk);
            while (busy)
                @(posedge clk);
        end
    endtask

    task automatic drain;
        begin
            start <= 1'b0;
            @(posedge clk);
            while (pending != 0)
                @(posedge clk);
            repeat (LATENCY + 4) @(posedge clk);
        end
    endtask

    task automatic set_tolerance(input sit_pkg::tol_t v);
        begin
            drain();
            tolerance_we <= 1'b1;
            tolerance    <= v;
            @(posedge clk);
            tolerance_we <= 1'b0;
        end
    endtask

    function automatic coord_t any_coord();
        case ($urandom_range(0, 5))
            0: return coord_t'($urandom);
            1: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            2: return coord_t'($signed($urandom_range(0, 64)) - 32);
            default: return coord_t'($signed($urandom_range(0, 32'hFFFF)) - 32768);
        endcase
    endfunction

    // Builds two segments that usually cross near a shared random point.
    task automatic crossing_pair(output coord_t v [8]);
        int cx, cy, r;
        begin
            r  = $urandom_range(0, 3) == 0 ? 3000000 : ($urandom_range(0, 1) ? 60000 : 500);
            cx = $signed($urandom_range(0, 2 * r)) - r;
            cy = $signed($urandom_range(0, 2 * r)) - r;
            for (int i = 0; i < 8; i += 2)
            begin
                v[i]   = coord_t'(cx + (($urandom_range(0, 1) ? 1 : -1) *
                                        $signed($urandom_range(0, r))));
                v[i+1] = coord_t'(cy + (($urandom_range(0, 1) ? 1 : -1) *
                                        $signed($urandom_range(0, r))));
            end
            // Point the ends of A and B through the center from their starts to force a crossing.
            if ($urandom_range(0, 1))
            begin
                v[6] = coord_t'(2 * cx - v[4]);
                v[7] = coord_t'(2 * cy - v[5]);
                v[2] = coord_t'(2 * cx - v[0]);
                v[3] = coord_t'(2 * cy - v[1]);
            end
        end
    endtask

    initial
    begin
        coord_t v [8];
        coord_t d [8];
        sit_pkg::tol_t tol_set [5];
        rst_n        = 1'b0;
        start        = 1'b0;
        tolerance_we = 1'b0;
        tolerance    = '0;
        for (int i = 0; i < 8; i++)
            pts[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pairs: plain cross, parallel, point-like, boxes apart,
        // outside bounds, saturating point, extremes of the range.
        d = '{-4096, 0, 4096, 0, 0, -4096, 0, 4096};              send_pair(d);
        d = '{0, 0, 4096, 0, 0, 4096, 4096, 4096};                send_pair(d);
        d = '{5, 5, 5, 5, 0, 0, 100, 100};                        send_pair(d);
        d = '{0, 0, 10, 10, 100, 0, 110, 20};                     send_pair(d);
        d = '{0, 0, 10, 0, 20, -5, 20, 5};                        send_pair(d);
        d = '{0, 0, 10, 0, 20, -5, 21, 5};                        send_pair(d);
        d = '{0, 0, 8388607, 1, 0, 2, 8388607, 4};                send_pair(d);
        d = '{-8388608, -8388608, 8388607, 8388607,
              -8388608, 8388607, 8388607, -8388608};              send_pair(d);
        d = '{-8388608, 0, 8388607, 0, 0, -8388608, 0, 8388607};  send_pair(d);
        d = '{0, 0, 0, 0, 0, 0, 0, 0};                            send_pair(d);
        d = '{0, 0, 8388607, 0, 0, 1, 8388607, 2};                send_pair(d);
        d = '{-1, -1, 1, 1, -1, 1, 1, -1};                        send_pair(d);
        d = '{0, 0, 4, 1, 4, 0, 0, 1};                            send_pair(d);

        tol_set = '{16'hFFFF, 16'd1, 16'd3000, 16'd0, 16'd65000};
        for (int p = 0; p < 5; p++)
        begin
            set_tolerance(tol_set[p]);
            if (p == 0)
            begin
                d = '{0, 0, 10, 0, 20, -5, 20, 5};
                send_pair(d);
            end
            for (int n = 0; n < 390; n++)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    for (int i = 0; i < 8; i++)
                        v[i] = any_coord();
                end
                else
                    crossing_pair(v);
                send_pair(v);
                if (n == 200)
                    drain();
            end
        end

        drain();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
